/* rtl/fys_pkg.sv */
// Shared types and constants for the shuffle engine.
`default_nettype none
package fys_pkg;

  localparam int ELEM_W = 32;
  localparam int RND_W  = 31;
  localparam int POS_W  = 5;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_RESTORE = 2'd2,
    MODE_SWAP    = 2'd3
  } mode_t;

endpackage
`default_nettype wire

/* rtl/fisher_yates_shuffle_engine.sv */
// Shuffle engine top level: list stores, modulo unit and sequencer.
//
//  channel   ports                                  handshake
//  command   mode, value, random_word               start, busy (taken when start && !busy)
//  result    element, position, last                strobe (one cycle, cannot be held off)
//
// Restore streams the original list back, one word per element.
// A swap step runs the bit-serial remainder unit, then two reads and two
// writes through the working store. The final step of a pass then streams
// the list out.
// Reset clears count, position, sequencer state and the pending result; list stores keep their contents.
// busy stays high until the last result word has left the strobe register.
`default_nettype none
module fisher_yates_shuffle_engine #(
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire fys_pkg::mode_t                       mode,
  input  wire logic signed [fys_pkg::ELEM_W-1:0]    value,
  input  wire logic        [fys_pkg::RND_W-1:0]     random_word,
  output logic                                      strobe,
  output logic signed [fys_pkg::ELEM_W-1:0]         element,
  output logic        [fys_pkg::POS_W-1:0]          position,
  output logic                                      last
);
  import fys_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int BW = $clog2(RND_W);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_RDI, S_RDJ, S_WRI, S_WRJ, S_EMIT, S_COPY
  } state_t;

  state_t              state;
  logic [CW-1:0]       element_count;
  logic [POS_W-1:0]    swap_position;
  logic [IW-1:0]       idx_i;
  logic [IW-1:0]       rem;
  logic [RND_W-1:0]    dvd;
  logic [BW-1:0]       bitcnt;
  logic [ELEM_W-1:0]   held;
  logic [IW-1:0]       k;
  logic                pend_valid;
  logic [IW-1:0]       pend_pos;
  logic                pend_last;
  logic                pend_copy;

  logic [ELEM_W-1:0]   orig_mem [DEPTH];
  logic [ELEM_W-1:0]   work_mem [DEPTH];
  logic [ELEM_W-1:0]   orig_rdata;
  logic [ELEM_W-1:0]   work_rdata;

  logic                accept;
  logic                can_load;
  logic [CW-1:0]       count_inc;
  logic [IW-1:0]       last_idx;
  logic [IW-1:0]       start_i;
  logic [IW:0]         dsr;
  logic [IW:0]         trial;
  logic [IW-1:0]       rem_next;

  logic                work_we;
  logic [IW-1:0]       work_waddr;
  logic [ELEM_W-1:0]   work_wdata;
  logic [IW-1:0]       work_raddr;
  logic                orig_we;

  function automatic logic [POS_W-1:0] rearm(input logic [CW-1:0] cnt);
    logic [CW-1:0] dec;
    dec = cnt - 1'b1;
    return (cnt == '0) ? '0 : POS_W'(dec);
  endfunction

  assign busy      = (state != S_IDLE) || pend_valid;
  assign accept    = start && !busy;
  assign can_load  = element_count < CW'(DEPTH);
  assign count_inc = element_count + 1'b1;
  assign last_idx  = IW'(element_count - 1'b1);

  // partner position walks down; clamp if the list shrank underneath it
  always_comb begin
    if (32'(swap_position) >= 32'(element_count)) begin
      start_i = last_idx;
    end else begin
      start_i = IW'(swap_position);
    end
  end

  // restoring remainder step, one dividend bit per cycle
  assign dsr   = {1'b0, idx_i} + 1'b1;
  assign trial = {rem, dvd[RND_W-1]};
  always_comb begin
    if (trial >= dsr) begin
      rem_next = IW'(trial - dsr);
    end else begin
      rem_next = IW'(trial);
    end
  end

  always_comb begin
    unique case (state)
      S_RDI:   work_raddr = idx_i;
      S_RDJ:   work_raddr = rem;
      default: work_raddr = k;
    endcase
  end

  always_comb begin
    orig_we    = accept && (mode == MODE_LOAD) && can_load;
    work_we    = 1'b0;
    work_waddr = IW'(element_count);
    work_wdata = value;
    priority if (pend_valid && pend_copy) begin
      work_we    = 1'b1;
      work_waddr = pend_pos;
      work_wdata = orig_rdata;
    end else if (state == S_WRI) begin
      work_we    = 1'b1;
      work_waddr = idx_i;
      work_wdata = work_rdata;
    end else if (state == S_WRJ) begin
      work_we    = 1'b1;
      work_waddr = rem;
      work_wdata = held;
    end else if (orig_we) begin
      work_we    = 1'b1;
    end else begin
      work_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (orig_we) begin
      orig_mem[IW'(element_count)] <= value;
    end
    orig_rdata <= orig_mem[k];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rdata <= work_mem[work_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_count <= '0;
      swap_position <= '0;
      pend_valid    <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_LOAD: begin
                if (can_load) begin
                  element_count <= count_inc;
                  swap_position <= rearm(count_inc);
                end
              end
              MODE_CLEAR: begin
                element_count <= '0;
                swap_position <= '0;
              end
              MODE_RESTORE: begin
                swap_position <= rearm(element_count);
                k             <= '0;
                if (element_count != '0) begin
                  state <= S_COPY;
                end
              end
              MODE_SWAP: begin
                idx_i  <= start_i;
                rem    <= '0;
                dvd    <= random_word;
                bitcnt <= BW'(RND_W - 1);
                if (element_count != '0) begin
                  state <= S_MOD;
                end
              end
            endcase
          end
        end
        S_MOD: begin
          rem <= rem_next;
          dvd <= {dvd[RND_W-2:0], 1'b0};
          if (bitcnt == '0) begin
            state <= S_RDI;
          end else begin
            bitcnt <= bitcnt - 1'b1;
          end
        end
        S_RDI: begin
          state <= S_RDJ;
        end
        S_RDJ: begin
          held  <= work_rdata;
          state <= S_WRI;
        end
        S_WRI: begin
          state <= S_WRJ;
        end
        S_WRJ: begin
          k <= '0;
          if (idx_i == '0) begin
            swap_position <= rearm(element_count);
            state         <= S_EMIT;
          end else begin
            swap_position <= POS_W'(idx_i - 1'b1);
            state         <= S_IDLE;
          end
        end
        S_EMIT, S_COPY: begin
          pend_valid <= 1'b1;
          pend_pos   <= k;
          pend_last  <= (k == last_idx);
          pend_copy  <= (state == S_COPY);
          if (k == last_idx) begin
            state <= S_IDLE;
          end else begin
            k <= k + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign strobe   = pend_valid;
  assign position = POS_W'(pend_pos);
  assign last     = pend_last;
  assign element  = pend_copy ? orig_rdata : work_rdata;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> ({1'b0, rem} < dsr))
    else $error("remainder not below divisor");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(element_count) <= DEPTH)
    else $error("element count beyond depth");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result word while not busy");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("word after last of list");

  a_work_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (element_count != '0))
    else $error("sequencer running on empty list");

endmodule
`default_nettype wire
